// ===== hdl/bust_pkg.sv =====
// ----------------------------------------------------------------------------
// bust_pkg
// Shared types and constants for the bounded unordered set table.
// ----------------------------------------------------------------------------
package bust_pkg;

    localparam int CMD_W           = 2;
    localparam int VALUE_W         = 32;
    localparam int STATUS_W        = 2;
    localparam int COUNT_W         = 7;
    localparam int MAX_ENTRIES_DEF = 64;

    localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

endpackage

// ===== hdl/bust_if.sv =====
// ----------------------------------------------------------------------------
// bust_if
// Valid/ready channels of the set table: command, response, configuration.
// ----------------------------------------------------------------------------
interface bust_req_if
    import bust_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface bust_rsp_if
    import bust_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] result_value;
    logic [COUNT_W-1:0]        fill_count;

    modport source (output valid, output status, output result_value, output fill_count,
                    input ready);
    modport sink   (input valid, input status, input result_value, input fill_count,
                    output ready);
endinterface

interface bust_cfg_if
    import bust_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

// ===== hdl/bust_ram.sv =====
// ----------------------------------------------------------------------------
// bust_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bust_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/bust_ctrl.sv =====
// ----------------------------------------------------------------------------
// bust_ctrl
// Sequencer: fill count, capacity register, search and shift-down walks over
// the entry RAM, and the response register.
// ----------------------------------------------------------------------------
module bust_ctrl
    import bust_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    bust_req_if.sink           req,
    bust_rsp_if.source         rsp,
    bust_cfg_if.sink           cfg,
    output logic               mem_we,
    output logic [ADDR_W-1:0]  mem_waddr,
    output logic [VALUE_W-1:0] mem_wdata,
    output logic [ADDR_W-1:0]  mem_raddr,
    input  logic [VALUE_W-1:0] mem_rdata
);

    // limit is MAX_ENTRIES clipped to the range of the 7-bit capacity register
    localparam logic [COUNT_W-1:0] MAX_CAP =
        (MAX_ENTRIES > 127) ? 7'd127 : COUNT_W'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [COUNT_W-1:0]        cap_reg;
    logic [COUNT_W-1:0]        idx_reg, idx_next;
    logic [VALUE_W-1:0]        key_reg, key_next;
    logic                      remove_reg, remove_next;
    status_t                   res_status_reg, res_status_next;
    logic [VALUE_W-1:0]        res_value_reg, res_value_next;
    logic                      out_valid_reg;
    status_t                   out_status_reg;
    logic [VALUE_W-1:0]        out_value_reg;
    logic [COUNT_W-1:0]        out_fill_reg;

    logic                      slot_free;
    logic                      accept;
    logic                      load_out;
    status_t                   load_status;
    logic [VALUE_W-1:0]        load_value;
    logic [COUNT_W-1:0]        eff_cap;
    logic [COUNT_W:0]          idx_p1, idx_p2, count_ext;
    logic                      hit;

    assign cfg.ready = 1'b1;

    assign eff_cap   = (cap_reg > MAX_CAP) ? MAX_CAP : cap_reg;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;

    assign idx_p1    = {1'b0, idx_reg} + (COUNT_W+1)'(1);
    assign idx_p2    = {1'b0, idx_reg} + (COUNT_W+1)'(2);
    assign count_ext = {1'b0, count_reg};
    assign hit       = (mem_rdata == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        remove_next     = remove_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        mem_we          = 1'b0;
        mem_waddr       = ADDR_W'(count_reg);
        mem_wdata       = req.value;
        mem_raddr       = '0;
        load_out        = 1'b0;
        load_status     = ST_NOT_FOUND;
        load_value      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(req.command))
                        CMD_INSERT:
                        begin
                            load_out = 1'b1;
                            if (count_reg < eff_cap)
                            begin
                                mem_we      = 1'b1;
                                count_next  = count_reg + COUNT_W'(1);
                                load_status = ST_OK;
                            end
                            else
                            begin
                                load_status = ST_FULL;
                            end
                        end
                        CMD_REMOVE, CMD_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                load_out = 1'b1;
                            end
                            else
                            begin
                                // address 0 read is issued this cycle
                                key_next    = req.value;
                                remove_next = (cmd_t'(req.command) == CMD_REMOVE);
                                idx_next    = '0;
                                state_next  = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // rdata holds entry idx; the read of idx+1 goes out now
                mem_raddr = ADDR_W'(idx_p1);
                if (hit)
                begin
                    res_status_next = ST_OK;
                    res_value_next  = mem_rdata;
                    if (remove_reg && (idx_p1 < count_ext))
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        if (remove_reg)
                        begin
                            count_next = count_reg - COUNT_W'(1);
                        end
                        state_next = S_DONE;
                    end
                end
                else if (idx_p1 < count_ext)
                begin
                    idx_next = idx_p1[COUNT_W-1:0];
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_value_next  = '0;
                    state_next      = S_DONE;
                end
            end

            S_SHIFT:
            begin
                // rdata holds entry idx+1; move it down to idx
                mem_raddr = ADDR_W'(idx_p2);
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(idx_reg);
                mem_wdata = mem_rdata;
                if (idx_p2 < count_ext)
                begin
                    idx_next = idx_p1[COUNT_W-1:0];
                end
                else
                begin
                    count_next = count_reg - COUNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    load_out    = 1'b1;
                    load_status = res_status_reg;
                    load_value  = res_value_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.capacity;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        remove_reg     <= remove_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (load_out)
        begin
            out_status_reg <= load_status;
            out_value_reg  <= load_value;
            out_fill_reg   <= count_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.fill_count   = out_fill_reg;

    // count stays within the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_ENTRIES)
        else $error("fill count beyond store depth");

    // count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((count_reg == $past(count_reg)) ||
                  (count_reg == $past(count_reg) + COUNT_W'(1)) ||
                  (count_reg + COUNT_W'(1) == $past(count_reg))))
        else $error("fill count jumped");

    // shift writes stay below the live count
    a_shift_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (idx_p1 < count_ext))
        else $error("shift write outside live entries");

    // no new command while a walk is in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SEARCH) || (state_reg == S_SHIFT)) |-> !req.ready)
        else $error("command accepted during walk");

    // a response is never overwritten before it is taken
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !load_out)
        else $error("response register overrun");

endmodule

// ===== hdl/bounded_unordered_set_table.sv =====
// ----------------------------------------------------------------------------
// bounded_unordered_set_table
// Unsorted packed array of signed 32-bit entries with fill count and
// configurable capacity; insert appends, remove compacts, query searches.
// ----------------------------------------------------------------------------
// One command is worked at a time and every command gives exactly one response
// beat. Insert, unknown codes, and remove or query on an empty table finish in
// the accept cycle and show on rsp the next cycle. A query walks the entries
// from entry 0 until its key first matches or all n live entries have missed,
// then posts the response from the done state. A remove walks the same
// search, then shifts each later entry down one slot before it posts the
// response. Both walks run one entry per cycle through the single read port
// of the entry RAM (registered read, reads issued one entry ahead of the
// compare); the shift writes entry i while it reads entry i+2, so read and
// write never collide. The response register lets the next command be taken
// in the same cycle that a finished response leaves. The entry RAM needs no
// clearing pass: only entries below the fill count are ever used. Capacity is
// written on cfg; the user keeps such writes to times the table is idle, as
// the block itself does not enforce it. The effective limit is the smaller of
// capacity and MAX_ENTRIES, and lowering it below the count only blocks inserts.
module bounded_unordered_set_table
    import bust_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bust_req_if.sink   req,
    bust_rsp_if.source rsp,
    bust_cfg_if.sink   cfg
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // entry RAM port signals
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    bust_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // packed entry store, one write and one registered read per cycle
    bust_ram #(
        .WIDTH  (VALUE_W),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== tb/tb_bounded_unordered_set_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_unordered_set_table
// Self-checking bench for the set table. A shadow copy of the table
// predicts every response beat. Directed edge cases come first, then
// capacity settings, then random traffic under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_bounded_unordered_set_table;
    import bust_pkg::*;

    localparam int          TABLE_DEPTH = MAX_ENTRIES_DEF;
    localparam int          CYCLE_LIMIT = 2_000_000;
    // cycles to sit after the last response before the verdict: a full
    // search plus a full compaction, with margin
    localparam int          TAIL_CYCLES = 2 * TABLE_DEPTH + 16;
    // command code the block has no operation for
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] found_value;
        logic [COUNT_W-1:0]        fill;
    } table_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    bust_req_if req_ch ();
    bust_rsp_if rsp_ch ();
    bust_cfg_if cfg_ch ();

    bounded_unordered_set_table #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow state: entries kept packed in a queue, index 0 is the oldest.
    logic signed [VALUE_W-1:0] table_shadow[$];
    logic [COUNT_W-1:0]        cap_shadow;

    // Responses still owed by the block, oldest first.
    table_reply_t reply_queue[$];
    table_reply_t oldest_reply;

    int error_count  = 0;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d responses outstanding",
                     $time, reply_queue.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor. Applies one command to the shadow table and returns the
    // response beat the block owes for it.
    // ------------------------------------------------------------------------
    function automatic table_reply_t predict_table_op(input logic [1:0] cmd,
                                                      input logic signed [VALUE_W-1:0] key);
        table_reply_t r;
        int           hit;
        int           limit;
        r.status      = ST_NOT_FOUND;
        r.found_value = '0;
        // capacity above the store is clipped to the store depth
        limit = (int'(cap_shadow) > TABLE_DEPTH) ? TABLE_DEPTH : int'(cap_shadow);
        // first match only; duplicates further up stay put
        hit = -1;
        for (int i = 0; i < table_shadow.size() && hit < 0; i++)
            if (table_shadow[i] == key)
                hit = i;
        case (cmd)
            CMD_INSERT:
            begin
                // a lowered capacity blocks inserts but discards nothing
                if (table_shadow.size() < limit)
                begin
                    table_shadow.push_back(key);
                    r.status = ST_OK;
                end
                else
                    r.status = ST_FULL;
            end
            CMD_REMOVE:
            begin
                if (hit >= 0)
                begin
                    r.found_value = table_shadow[hit];
                    table_shadow.delete(hit);
                    r.status = ST_OK;
                end
            end
            CMD_QUERY:
            begin
                if (hit >= 0)
                begin
                    r.found_value = table_shadow[hit];
                    r.status = ST_OK;
                end
            end
            default: ; // unused code: not found, table untouched
        endcase
        r.fill = COUNT_W'(table_shadow.size());
        return r;
    endfunction

    // Key mix: mostly live entries so removes and queries hit, a small pool
    // for duplicates, and full-range noise for the rest.
    function automatic logic signed [VALUE_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 55 && table_shadow.size() > 0)
            return table_shadow[$urandom_range(table_shadow.size() - 1)];
        else if (r < 80)
            return int'($urandom_range(12)) - 6;
        else
            return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // Command sender. Valid stays high across back-to-back beats and is only
    // dropped when an idle gap is inserted or the table is drained.
    // ------------------------------------------------------------------------
    task automatic send_table_cmd(input logic [1:0] cmd,
                                  input logic signed [VALUE_W-1:0] key);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.value   <= key;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        // beat taken at this edge: predict in acceptance order
        reply_queue.push_back(predict_table_op(cmd, key));
    endtask

    // Drop valid, wait out every owed response, then let the block settle.
    task automatic wait_table_idle(input int settle);
        req_ch.valid <= 1'b0;
        while (reply_queue.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Capacity is only written with the table idle.
    task automatic write_capacity(input logic [COUNT_W-1:0] cap);
        wait_table_idle(4);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= cap;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        cap_shadow = cap;
    endtask

    // ------------------------------------------------------------------------
    // Response checker plus random receiver back-pressure. Fields are sampled
    // at the edge, before this edge's updates land.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (reply_queue.size() == 0)
            begin
                $display("%0t: unexpected response beat: status %0d value %0d fill %0d",
                         $time, rsp_ch.status, rsp_ch.result_value, rsp_ch.fill_count);
                error_count++;
            end
            else
            begin
                oldest_reply = reply_queue.pop_front();
                if (rsp_ch.status !== oldest_reply.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, oldest_reply.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.result_value !== oldest_reply.found_value)
                begin
                    $display("%0t: result_value mismatch: expected %0d, got %0d",
                             $time, oldest_reply.found_value, rsp_ch.result_value);
                    error_count++;
                end
                if (rsp_ch.fill_count !== oldest_reply.fill)
                begin
                    $display("%0t: fill_count mismatch: expected %0d, got %0d",
                             $time, oldest_reply.fill, rsp_ch.fill_count);
                    error_count++;
                end
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty table, extreme values, duplicates, first/last removal, misses and
    // the unused command code. Capacity is still at its reset value here.
    task automatic test_directed_edges();
        send_table_cmd(CMD_QUERY,  0);          // empty table
        send_table_cmd(CMD_REMOVE, 0);          // empty table
        send_table_cmd(CMD_INSERT, VAL_MIN);
        send_table_cmd(CMD_INSERT, VAL_MAX);
        send_table_cmd(CMD_INSERT, 0);
        send_table_cmd(CMD_INSERT, -1);
        send_table_cmd(CMD_INSERT, 5);
        send_table_cmd(CMD_INSERT, 5);          // duplicate key
        send_table_cmd(CMD_INSERT, 7);
        send_table_cmd(CMD_QUERY,  5);
        send_table_cmd(CMD_REMOVE, 5);          // first copy only
        send_table_cmd(CMD_QUERY,  5);          // second copy still there
        send_table_cmd(CMD_QUERY,  VAL_MAX);
        send_table_cmd(CMD_REMOVE, VAL_MIN);    // head: shifts everything
        send_table_cmd(CMD_REMOVE, 7);          // tail: no shift
        send_table_cmd(CMD_REMOVE, 12345);      // miss over the full walk
        send_table_cmd(CMD_QUERY,  -2);
        send_table_cmd(CMD_UNUSED, -1);
        send_table_cmd(CMD_UNUSED, VAL_MAX);
        send_table_cmd(CMD_QUERY,  -1);
        wait_table_idle(4);
    endtask

    // Capacity below the count, zero, above the store, and one.
    task automatic test_capacity_settings();
        write_capacity(7'd2);                   // count is 4 here
        send_table_cmd(CMD_INSERT, 9);
        send_table_cmd(CMD_QUERY,  -1);
        send_table_cmd(CMD_REMOVE, 0);
        send_table_cmd(CMD_INSERT, 9);          // still above the limit
        write_capacity(7'd0);
        send_table_cmd(CMD_INSERT, 1);
        send_table_cmd(CMD_REMOVE, 5);
        send_table_cmd(CMD_INSERT, 1);
        // register above the store: fill to the store depth, then one more
        write_capacity(7'd127);
        while (table_shadow.size() < TABLE_DEPTH)
            send_table_cmd(CMD_INSERT, $urandom);
        send_table_cmd(CMD_INSERT, 42);
        send_table_cmd(CMD_QUERY, table_shadow[TABLE_DEPTH - 1]);  // longest hit
        send_table_cmd(CMD_REMOVE, table_shadow[0]);                // longest shift
        write_capacity(7'd1);
        send_table_cmd(CMD_INSERT, 3);
        send_table_cmd(CMD_REMOVE, table_shadow[table_shadow.size() / 2]);
        wait_table_idle(4);
    endtask

    task automatic run_traffic_phase(input logic [COUNT_W-1:0] cap,
                                     input int idle_pct, input int stall_pct,
                                     input int n_items, input int insert_pct);
        int         r;
        logic [1:0] cmd;
        write_capacity(cap);
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++)
        begin
            r = $urandom_range(99);
            if (r < insert_pct)
                cmd = CMD_INSERT;
            else if (r < 96)
                cmd = $urandom_range(1) ? CMD_REMOVE : CMD_QUERY;
            else
                cmd = CMD_UNUSED;
            send_table_cmd(cmd, pick_key());
        end
    endtask

    // Random traffic: drain, small capacity with the limit hit often, capacity
    // above the store with the table near full, then a balanced mix.
    task automatic test_random_traffic();
        run_traffic_phase(7'd64,  0,  0,  280, 30);
        run_traffic_phase(7'd5,   55, 0,  260, 55);
        run_traffic_phase(7'd127, 0,  55, 280, 60);
        run_traffic_phase(7'd64,  25, 25, 280, 40);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.command  = CMD_INSERT;
        req_ch.value    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.capacity = CAP_RESET;
        rsp_ch.ready    = 1'b1;
        cap_shadow      = CAP_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_capacity_settings();
        test_random_traffic();

        // anything the block sends after this point is flagged by the checker
        wait_table_idle(TAIL_CYCLES);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
